/* design/snv_pkg.sv */
// ----------------------------------------------------------------------------
// snv_pkg
// shared types and constants of the snv c/n0 estimator
// ----------------------------------------------------------------------------
`default_nettype none

package snv_pkg;

    localparam int FRAC_BITS     = 12;
    localparam int LOG_FRAC_BITS = 16;
    localparam int MANT_W        = 31;
    localparam int DB_W          = 16;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int ALPHA_W       = 16;
    localparam int DBL_W         = 19;

    localparam logic signed [DBL_W-1:0] DB_PER_LOG2 = 19'sd197283;
    localparam logic signed [17:0]      NSR_CAP     = 18'sd40960;
    localparam logic signed [DB_W-1:0]  CN0_MAX     = 16'sh7fff;
    localparam logic signed [DB_W-1:0]  CN0_MIN     = 16'sh8000;
    localparam logic signed [DB_W-1:0]  INIT_EST    = 16'sd10240;
    localparam logic [ALPHA_W-1:0]      ALPHA_RST   = 16'd6554;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IIR_COEF  = 2'd0,
        REG_BW_OFFSET = 2'd1,
        REG_INIT_EST  = 2'd2,
        REG_UNUSED    = 2'd3
    } snv_reg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ACC,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_IIR_INIT,
        OP_IIR_STEP,
        OP_IIR_END,
        OP_SQR_STEP,
        OP_NORM_INIT,
        OP_NORM_STEP,
        OP_LOG_INIT,
        OP_LOG_STEP,
        OP_SCALE,
        OP_FINISH
    } snv_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_DIV_INIT,
        S_DIV,
        S_DIV_END,
        S_IIR_INIT,
        S_IIR,
        S_IIR_END,
        S_SQR,
        S_CHECK,
        S_NORM,
        S_LOG_INIT,
        S_LOG,
        S_SCALE,
        S_FINISH,
        S_OUT
    } snv_state_t;

    typedef struct packed {
        snv_op_t op;
        logic    out_load;
    } snv_cmd_t;

    typedef struct packed {
        logic warm_gt1;
        logic warm_ne0;
        logic ps_ge_pt;
        logic ps_zero;
    } snv_status_t;

endpackage

`default_nettype wire

/* design/snv_in_if.sv */
// ----------------------------------------------------------------------------
// snv_in_if
// input channel: one i/q correlator pair per item
// ----------------------------------------------------------------------------
`default_nettype none

interface snv_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_phase;
    logic signed [SAMPLE_BITS-1:0] quadrature;

    modport source (output valid, output in_phase, output quadrature, input ready);
    modport sink   (input valid, input in_phase, input quadrature, output ready);
endinterface

`default_nettype wire

/* design/snv_out_if.sv */
// ----------------------------------------------------------------------------
// snv_out_if
// output channel: one c/n0 estimate per item
// ----------------------------------------------------------------------------
`default_nettype none

interface snv_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] cn0_estimate;
    logic               estimate_live;

    modport source (output valid, output cn0_estimate, output estimate_live, input ready);
    modport sink   (input valid, input cn0_estimate, input estimate_live, output ready);
endinterface

`default_nettype wire

/* design/snv_cn0_estimator_top.sv */
// ----------------------------------------------------------------------------
// snv_cn0_estimator_top
// c/n0 estimator: warm-up sums, iir averages, log2 based nsr, q8.8 db-hz out
// warm-up items accumulate, the scaling item runs the reciprocal divide,
// tracking items iir, square, then normalise and log2 unless saturated
// one item at a time, set by the serial iir, square and log2 steps
// the next item is taken while the last result waits in the output register
// rst_n clears the averages, restarts warm-up and loads the register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module snv_cn0_estimator_top
    import snv_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int WARMUP_LEN  = 20
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    snv_in_if.sink                    in_chan,
    snv_out_if.source                 out_chan
);

    localparam int CW     = $clog2(WARMUP_LEN);
    localparam int AMP_W  = SAMPLE_BITS + FRAC_BITS - 1 + CW;
    localparam int POW_W  = 2 * SAMPLE_BITS + FRAC_BITS - 1 + CW;
    localparam int SQ_W   = 2 * AMP_W;
    localparam int PT_W   = POW_W + FRAC_BITS;
    localparam int LW     = (SQ_W > PT_W) ? SQ_W : PT_W;

    snv_cmd_t    cmd;
    snv_status_t status;

    snv_controller #(
        .AMP_W      (AMP_W),
        .POW_W      (POW_W),
        .NORM_STEPS ($clog2(LW)),
        .DIV_STEPS  ((POW_W + 16) / 16)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_chan.valid),
        .in_ready  (in_chan.ready),
        .out_valid (out_chan.valid),
        .out_ready (out_chan.ready),
        .status    (status),
        .cmd       (cmd)
    );

    snv_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WARMUP_LEN  (WARMUP_LEN)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_phase      (in_chan.in_phase),
        .quadrature    (in_chan.quadrature),
        .cmd           (cmd),
        .status        (status),
        .cn0_estimate  (out_chan.cn0_estimate),
        .estimate_live (out_chan.estimate_live)
    );

endmodule

`default_nettype wire

/* design/snv_datapath.sv */
// ----------------------------------------------------------------------------
// snv_datapath
// averages, reciprocal constant divide, serial iir, serial square, log2 and db
// ----------------------------------------------------------------------------
`default_nettype none

module snv_datapath
    import snv_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int WARMUP_LEN  = 20
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_W-1:0]              cfg_data,
    input  wire logic signed [SAMPLE_BITS-1:0] in_phase,
    input  wire logic signed [SAMPLE_BITS-1:0] quadrature,
    input  wire snv_cmd_t                      cmd,
    output snv_status_t                        status,
    output logic signed [DB_W-1:0]             cn0_estimate,
    output logic                               estimate_live
);

    localparam int CW     = $clog2(WARMUP_LEN);
    localparam int WC_W   = $clog2(WARMUP_LEN + 1);
    localparam int AMP_W  = SAMPLE_BITS + FRAC_BITS - 1 + CW;
    localparam int POW_W  = 2 * SAMPLE_BITS + FRAC_BITS - 1 + CW;
    localparam int SQ_W   = 2 * AMP_W;
    localparam int PT_W   = POW_W + FRAC_BITS;
    localparam int LW     = (SQ_W > PT_W) ? SQ_W : PT_W;
    localparam int E_W    = $clog2(LW);
    localparam int LL_W   = E_W + LOG_FRAC_BITS + 1;
    localparam int PR_W   = LL_W + DBL_W;
    localparam int NW     = PR_W - 24;
    localparam int EW     = NW + 1;
    localparam int XP_W   = 2 * SAMPLE_BITS;
    localparam int DV_K   = POW_W + CW;
    localparam int DV_S   = (POW_W + 16) / 16;
    localparam int M_W    = 16 * DV_S;
    localparam int AC_W   = M_W + DV_K;

    localparam logic [WC_W-1:0]  WARM_RST = WC_W'(WARMUP_LEN);
    localparam logic [POW_W-1:0] HALF_W   = POW_W'(WARMUP_LEN / 2);
    localparam logic [DV_K:0]    DV_POW   = {1'b1, {DV_K{1'b0}}};
    localparam logic [M_W-1:0]   RECIP    = M_W'((DV_POW + (DV_K + 1)'(WARMUP_LEN - 1))
                                                 / (DV_K + 1)'(WARMUP_LEN));
    localparam logic [E_W-1:0]   E_TOP    = E_W'(LW - 1);
    localparam logic [E_W-1:0]   SH_FIRST = E_W'(1 << (E_W - 1));
    localparam logic signed [PR_W-1:0] RND = PR_W'(1 << 23);

    // configuration and state
    logic [ALPHA_W-1:0]      alpha_reg, alpha_next;
    logic signed [DB_W-1:0]  offset_reg, offset_next;
    logic [WC_W-1:0]         warm_reg, warm_next;
    logic [AMP_W-1:0]        amp_reg, amp_next;
    logic [POW_W-1:0]        pow_reg, pow_next;
    logic signed [DB_W-1:0]  last_reg, last_next;
    logic                    live_reg, live_next;

    // working registers
    logic [SAMPLE_BITS-1:0]     xa_reg, xa_next;
    logic [XP_W-1:0]            xp_reg, xp_next;
    logic [POW_W-1:0]           qa_reg, qa_next, qp_reg, qp_next;
    logic [AC_W-1:0]            pa_reg, pa_next, pp_reg, pp_next;
    logic [M_W-1:0]             mb_reg, mb_next;
    logic signed [AMP_W:0]      da_reg, da_next;
    logic signed [POW_W:0]      dp_reg, dp_next;
    logic signed [AMP_W+16:0]   ta_reg, ta_next;
    logic signed [POW_W+16:0]   tp_reg, tp_next;
    logic [ALPHA_W-1:0]         alb_reg, alb_next;
    logic [AMP_W-1:0]           sqb_reg, sqb_next;
    logic [SQ_W-1:0]            ps_reg, ps_next;
    logic [LW-1:0]              zn_reg, zn_next, zs_reg, zs_next;
    logic [E_W-1:0]             en_reg, en_next, es_reg, es_next, sh_reg, sh_next;
    logic [MANT_W-1:0]          mn_reg, mn_next, ms_reg, ms_next;
    logic [LOG_FRAC_BITS-1:0]   rn_reg, rn_next, rs_reg, rs_next;
    logic signed [PR_W-1:0]     scl_reg, scl_next;
    logic signed [DB_W-1:0]     cn0_reg, cn0_next;
    logic                       lout_reg, lout_next;

    // combinational helpers
    logic signed [XP_W-1:0]     ii, qq;
    logic [LW-1:0]              ps_ext, pt_ext, top_mask;
    logic [POW_W+15:0]          prod_a, prod_p;
    logic [AMP_W+16:0]          amp_sum;
    logic [POW_W+16:0]          pow_sum;
    logic [AMP_W-1:0]           amp_new;
    logic [2*MANT_W-1:0]        sqn, sqs;
    logic signed [LL_W-1:0]     lg_diff;
    logic signed [PR_W-1:0]     rnd_sum;
    logic signed [NW-1:0]       nsr, nsr_c;
    logic signed [EW-1:0]       est_w;
    logic signed [DB_W-1:0]     est;

    assign ps_ext = LW'(ps_reg);
    assign pt_ext = LW'({pow_reg, {FRAC_BITS{1'b0}}});

    assign status.warm_gt1 = (warm_reg > WC_W'(1));
    assign status.warm_ne0 = (warm_reg != '0);
    assign status.ps_ge_pt = (ps_ext >= pt_ext);
    assign status.ps_zero  = (ps_reg == '0);

    assign cn0_estimate  = cn0_reg;
    assign estimate_live = lout_reg;

    always_comb
    begin
        alpha_next  = alpha_reg;
        offset_next = offset_reg;
        warm_next   = warm_reg;
        amp_next    = amp_reg;
        pow_next    = pow_reg;
        last_next   = last_reg;
        live_next   = live_reg;
        xa_next     = xa_reg;
        xp_next     = xp_reg;
        qa_next     = qa_reg;
        qp_next     = qp_reg;
        pa_next     = pa_reg;
        pp_next     = pp_reg;
        mb_next     = mb_reg;
        da_next     = da_reg;
        dp_next     = dp_reg;
        ta_next     = ta_reg;
        tp_next     = tp_reg;
        alb_next    = alb_reg;
        sqb_next    = sqb_reg;
        ps_next     = ps_reg;
        zn_next     = zn_reg;
        zs_next     = zs_reg;
        en_next     = en_reg;
        es_next     = es_reg;
        sh_next     = sh_reg;
        mn_next     = mn_reg;
        ms_next     = ms_reg;
        rn_next     = rn_reg;
        rs_next     = rs_reg;
        scl_next    = scl_reg;
        cn0_next    = cn0_reg;
        lout_next   = lout_reg;

        ii       = in_phase * in_phase;
        qq       = quadrature * quadrature;
        prod_a   = qa_reg * mb_reg[M_W-1 -: 16];
        prod_p   = qp_reg * mb_reg[M_W-1 -: 16];
        amp_sum  = {1'b0, amp_reg, 16'd0} + (AMP_W + 17)'(ta_reg) + (AMP_W + 17)'(32768);
        pow_sum  = {1'b0, pow_reg, 16'd0} + (POW_W + 17)'(tp_reg) + (POW_W + 17)'(32768);
        amp_new  = amp_sum[AMP_W+15:16];
        top_mask = ~({LW{1'b1}} >> sh_reg);
        sqn      = {{MANT_W{1'b0}}, mn_reg} * {{MANT_W{1'b0}}, mn_reg};
        sqs      = {{MANT_W{1'b0}}, ms_reg} * {{MANT_W{1'b0}}, ms_reg};
        lg_diff  = $signed({1'b0, en_reg, rn_reg}) - $signed({1'b0, es_reg, rs_reg});
        rnd_sum  = scl_reg + RND;
        nsr      = rnd_sum[PR_W-1:24];
        if (status.ps_zero || nsr > NW'(NSR_CAP))
        begin
            nsr_c = NW'(NSR_CAP);
        end
        else
        begin
            nsr_c = nsr;
        end
        est_w = EW'(offset_reg) - EW'(nsr_c);
        if (status.ps_ge_pt || est_w > EW'(CN0_MAX))
        begin
            est = CN0_MAX;
        end
        else if (est_w < EW'(CN0_MIN))
        begin
            est = CN0_MIN;
        end
        else
        begin
            est = est_w[DB_W-1:0];
        end

        case (cmd.op)
            OP_LOAD:
            begin
                xa_next   = in_phase[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_phase)
                                                    : SAMPLE_BITS'(in_phase);
                xp_next   = XP_W'($unsigned(ii)) + XP_W'($unsigned(qq));
                live_next = 1'b0;
            end
            OP_ACC:
            begin
                amp_next  = amp_reg + AMP_W'({xa_reg, {FRAC_BITS{1'b0}}});
                pow_next  = pow_reg + POW_W'({xp_reg, {FRAC_BITS{1'b0}}});
                warm_next = warm_reg - WC_W'(1);
            end
            OP_DIV_INIT:
            begin
                qa_next = POW_W'(amp_reg) + HALF_W;
                qp_next = pow_reg + HALF_W;
                pa_next = '0;
                pp_next = '0;
                mb_next = RECIP;
            end
            OP_DIV_STEP:
            begin
                // multiply by the reciprocal, 16 bits of it per step
                pa_next = (pa_reg << 16) + AC_W'(prod_a);
                pp_next = (pp_reg << 16) + AC_W'(prod_p);
                mb_next = mb_reg << 16;
            end
            OP_DIV_END:
            begin
                amp_next  = pa_reg[DV_K +: AMP_W];
                pow_next  = pp_reg[DV_K +: POW_W];
                warm_next = '0;
            end
            OP_IIR_INIT:
            begin
                da_next  = $signed({1'b0, AMP_W'({xa_reg, {FRAC_BITS{1'b0}}})})
                         - $signed({1'b0, amp_reg});
                dp_next  = $signed({1'b0, POW_W'({xp_reg, {FRAC_BITS{1'b0}}})})
                         - $signed({1'b0, pow_reg});
                ta_next  = '0;
                tp_next  = '0;
                alb_next = alpha_reg;
            end
            OP_IIR_STEP:
            begin
                ta_next  = (ta_reg <<< 1) + (alb_reg[ALPHA_W-1] ? (AMP_W + 17)'(da_reg)
                                                                : '0);
                tp_next  = (tp_reg <<< 1) + (alb_reg[ALPHA_W-1] ? (POW_W + 17)'(dp_reg)
                                                                : '0);
                alb_next = {alb_reg[ALPHA_W-2:0], 1'b0};
            end
            OP_IIR_END:
            begin
                amp_next = amp_new;
                pow_next = pow_sum[POW_W+15:16];
                sqb_next = amp_new;
                ps_next  = '0;
            end
            OP_SQR_STEP:
            begin
                ps_next  = (ps_reg << 1) + (sqb_reg[AMP_W-1] ? SQ_W'(amp_reg) : '0);
                sqb_next = {sqb_reg[AMP_W-2:0], 1'b0};
            end
            OP_NORM_INIT:
            begin
                zn_next = pt_ext - ps_ext;
                zs_next = ps_ext;
                en_next = E_TOP;
                es_next = E_TOP;
                sh_next = SH_FIRST;
            end
            OP_NORM_STEP:
            begin
                if ((zn_reg & top_mask) == '0)
                begin
                    zn_next = zn_reg << sh_reg;
                    en_next = en_reg - sh_reg;
                end
                if ((zs_reg & top_mask) == '0)
                begin
                    zs_next = zs_reg << sh_reg;
                    es_next = es_reg - sh_reg;
                end
                sh_next = sh_reg >> 1;
            end
            OP_LOG_INIT:
            begin
                mn_next = zn_reg[LW-1 -: MANT_W];
                ms_next = zs_reg[LW-1 -: MANT_W];
                rn_next = '0;
                rs_next = '0;
            end
            OP_LOG_STEP:
            begin
                if (sqn[2*MANT_W-1])
                begin
                    mn_next = sqn[2*MANT_W-1:MANT_W];
                    rn_next = {rn_reg[LOG_FRAC_BITS-2:0], 1'b1};
                end
                else
                begin
                    mn_next = sqn[2*MANT_W-2:MANT_W-1];
                    rn_next = {rn_reg[LOG_FRAC_BITS-2:0], 1'b0};
                end
                if (sqs[2*MANT_W-1])
                begin
                    ms_next = sqs[2*MANT_W-1:MANT_W];
                    rs_next = {rs_reg[LOG_FRAC_BITS-2:0], 1'b1};
                end
                else
                begin
                    ms_next = sqs[2*MANT_W-2:MANT_W-1];
                    rs_next = {rs_reg[LOG_FRAC_BITS-2:0], 1'b0};
                end
            end
            OP_SCALE:
            begin
                scl_next = PR_W'(lg_diff) * PR_W'(DB_PER_LOG2);
            end
            OP_FINISH:
            begin
                last_next = est;
                live_next = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (cmd.out_load)
        begin
            cn0_next  = last_reg;
            lout_next = live_reg;
        end

        if (cfg_write)
        begin
            case (snv_reg_t'(cfg_index))
                REG_IIR_COEF:  alpha_next  = cfg_data[ALPHA_W-1:0];
                REG_BW_OFFSET: offset_next = $signed(cfg_data[DB_W-1:0]);
                REG_INIT_EST:
                begin
                    if (warm_reg != '0)
                    begin
                        last_next = $signed(cfg_data[DB_W-1:0]);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg  <= ALPHA_RST;
            offset_reg <= '0;
            warm_reg   <= WARM_RST;
            amp_reg    <= '0;
            pow_reg    <= '0;
            last_reg   <= INIT_EST;
            live_reg   <= 1'b0;
        end
        else
        begin
            alpha_reg  <= alpha_next;
            offset_reg <= offset_next;
            warm_reg   <= warm_next;
            amp_reg    <= amp_next;
            pow_reg    <= pow_next;
            last_reg   <= last_next;
            live_reg   <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xa_reg   <= xa_next;
        xp_reg   <= xp_next;
        qa_reg   <= qa_next;
        qp_reg   <= qp_next;
        pa_reg   <= pa_next;
        pp_reg   <= pp_next;
        mb_reg   <= mb_next;
        da_reg   <= da_next;
        dp_reg   <= dp_next;
        ta_reg   <= ta_next;
        tp_reg   <= tp_next;
        alb_reg  <= alb_next;
        sqb_reg  <= sqb_next;
        ps_reg   <= ps_next;
        zn_reg   <= zn_next;
        zs_reg   <= zs_next;
        en_reg   <= en_next;
        es_reg   <= es_next;
        sh_reg   <= sh_next;
        mn_reg   <= mn_next;
        ms_reg   <= ms_next;
        rn_reg   <= rn_next;
        rs_reg   <= rs_next;
        scl_reg  <= scl_next;
        cn0_reg  <= cn0_next;
        lout_reg <= lout_next;
    end

endmodule

`default_nettype wire

/* design/snv_controller.sv */
// ----------------------------------------------------------------------------
// snv_controller
// sequences one item through the datapath and holds the output valid
// ----------------------------------------------------------------------------
`default_nettype none

module snv_controller
    import snv_pkg::*;
#(
    parameter int AMP_W      = 32,
    parameter int POW_W      = 48,
    parameter int NORM_STEPS = 6,
    parameter int DIV_STEPS  = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire snv_status_t status,
    output snv_cmd_t         cmd
);

    localparam int CNT_W = $clog2(POW_W + 1);

    snv_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ov_reg, ov_next;

    assign out_valid = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        in_ready     = 1'b0;
        cmd.op       = OP_NONE;
        cmd.out_load = 1'b0;
        ov_next      = ov_reg && !out_ready;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    if (status.warm_gt1)
                    begin
                        state_next = S_ACC;
                    end
                    else if (status.warm_ne0)
                    begin
                        state_next = S_DIV_INIT;
                    end
                    else
                    begin
                        state_next = S_IIR_INIT;
                    end
                end
            end
            S_ACC:
            begin
                cmd.op     = OP_ACC;
                state_next = S_OUT;
            end
            S_DIV_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                cnt_next   = CNT_W'(DIV_STEPS - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_DIV_END;
                end
            end
            S_DIV_END:
            begin
                cmd.op     = OP_DIV_END;
                state_next = S_OUT;
            end
            S_IIR_INIT:
            begin
                cmd.op     = OP_IIR_INIT;
                cnt_next   = CNT_W'(ALPHA_W - 1);
                state_next = S_IIR;
            end
            S_IIR:
            begin
                cmd.op   = OP_IIR_STEP;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_IIR_END;
                end
            end
            S_IIR_END:
            begin
                cmd.op     = OP_IIR_END;
                cnt_next   = CNT_W'(AMP_W - 1);
                state_next = S_SQR;
            end
            S_SQR:
            begin
                cmd.op   = OP_SQR_STEP;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.ps_ge_pt || status.ps_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.op     = OP_NORM_INIT;
                    cnt_next   = CNT_W'(NORM_STEPS - 1);
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                cmd.op   = OP_NORM_STEP;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_LOG_INIT;
                end
            end
            S_LOG_INIT:
            begin
                cmd.op     = OP_LOG_INIT;
                cnt_next   = CNT_W'(LOG_FRAC_BITS - 1);
                state_next = S_LOG;
            end
            S_LOG:
            begin
                cmd.op   = OP_LOG_STEP;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                cmd.op     = OP_SCALE;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.op     = OP_FINISH;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> (state_reg != S_IDLE))
        else $error("item accepted but controller stayed idle");

    a_out_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && ov_reg && !out_ready) |=> (state_reg == S_OUT))
        else $error("result overwrote an item not yet taken");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == '0) |=> (state_reg == S_DIV_END))
        else $error("divide did not finish after its last step");

    a_saturate_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK && status.ps_ge_pt) |=> (state_reg == S_FINISH))
        else $error("log path taken with no noise power");
`endif

endmodule

`default_nettype wire

/* sim/snv_cn0_estimator_top_tb.sv */
// ----------------------------------------------------------------------------
// snv_cn0_estimator_top_tb
// drives i/q items through the c/n0 estimator and checks every estimate
// against a bit-exact predictor of the warm-up sums, iir averages and log2 nsr,
// with random gaps on both channels and register changes between phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module snv_cn0_estimator_top_tb;
    import snv_pkg::*;

    localparam int WARMUP      = 20;
    localparam int DRAIN_WAIT  = 120;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic signed [15:0] i_val;
        logic signed [15:0] q_val;
    } iq_item_t;

    typedef struct packed {
        logic signed [15:0] cn0;
        logic               live;
    } estimate_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    snv_in_if #(.SAMPLE_BITS(16)) in_chan ();
    snv_out_if out_chan ();

    snv_cn0_estimator_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_chan  (in_chan),
        .out_chan (out_chan)
    );

    iq_item_t  pending_items[$];
    estimate_t estimate_q[$];
    int errors;
    int idle_cycles;
    bit gaps_on;

    // predictor state
    bit [4:0]           warm_left;
    bit [63:0]          amp_avg;
    bit [63:0]          pow_avg;
    logic signed [15:0] last_est;
    bit [15:0]          alpha;
    logic signed [15:0] bw_offset;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    task automatic report(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    function automatic longint log2_fix(input bit [63:0] x);
        int        e;
        bit [63:0] m;
        longint    r;
        e = 63;
        r = 0;
        while (x[e] == 1'b0 && e > 0)
            e--;
        m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
        for (int k = 0; k < LOG_FRAC_BITS; k++)
        begin
            m = (m * m) >> 30;
            r = r << 1;
            if (m >= (64'd2 << 30))
            begin
                r = r | 1;
                m = m >> 1;
            end
        end
        return longint'(e) * 65536 + r;
    endfunction

    function automatic bit [63:0] iir_update(input bit [63:0] avg, input bit [63:0] x);
        bit [63:0] a;
        a = alpha;
        return (avg * (64'd65536 - a) + a * x + 64'd32768) >> 16;
    endfunction

    function automatic void reg_update(input snv_reg_t idx, input logic [15:0] data);
        case (idx)
            REG_IIR_COEF:  alpha = data;
            REG_BW_OFFSET: bw_offset = data;
            REG_INIT_EST:  if (warm_left != 0) last_est = data;
            default: ;
        endcase
    endfunction

    function automatic estimate_t cn0_predict(input iq_item_t it);
        longint    i_s;
        longint    q_s;
        bit [63:0] amp_in;
        bit [63:0] pow_in;
        bit [63:0] ps;
        bit [63:0] pt;
        longint    nsr;
        longint    est;
        estimate_t res;
        i_s = it.i_val;
        q_s = it.q_val;
        amp_in = (i_s < 0) ? -i_s : i_s;
        pow_in = i_s * i_s + q_s * q_s;
        res.live = 1'b0;
        if (warm_left > 1)
        begin
            amp_avg += amp_in << FRAC_BITS;
            pow_avg += pow_in << FRAC_BITS;
            warm_left--;
        end
        else if (warm_left == 1)
        begin
            warm_left = 0;
            amp_avg = (amp_avg + WARMUP / 2) / WARMUP;
            pow_avg = (pow_avg + WARMUP / 2) / WARMUP;
        end
        else
        begin
            amp_avg = iir_update(amp_avg, amp_in << FRAC_BITS);
            pow_avg = iir_update(pow_avg, pow_in << FRAC_BITS);
            ps = amp_avg * amp_avg;
            pt = pow_avg << FRAC_BITS;
            if (ps >= pt)
                est = longint'(CN0_MAX);
            else
            begin
                if (ps == 0)
                    nsr = longint'(NSR_CAP);
                else
                begin
                    nsr = ((log2_fix(pt - ps) - log2_fix(ps)) * longint'(DB_PER_LOG2)
                          + (longint'(1) << 23)) >>> 24;
                    if (nsr > longint'(NSR_CAP))
                        nsr = longint'(NSR_CAP);
                end
                est = longint'(bw_offset) - nsr;
                if (est > longint'(CN0_MAX))
                    est = longint'(CN0_MAX);
                if (est < longint'(CN0_MIN))
                    est = longint'(CN0_MIN);
            end
            last_est = est[15:0];
            res.live = 1'b1;
        end
        res.cn0 = last_est;
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!gaps_on || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic iq_item_t random_item();
        iq_item_t it;
        int       amp;
        case ($urandom_range(0, 3))
            0:
            begin
                it.i_val = $urandom;
                it.q_val = $urandom;
            end
            1:
            begin
                amp = $urandom_range(100, 30000);
                it.i_val = amp + $signed($urandom_range(0, 200)) - 100;
                if ($urandom_range(0, 1))
                    it.i_val = -it.i_val;
                it.q_val = $signed($urandom_range(0, 400)) - 200;
            end
            2:
            begin
                it.i_val = $signed($urandom_range(0, 16)) - 8;
                it.q_val = $signed($urandom_range(0, 16)) - 8;
            end
            default:
            begin
                amp = $urandom_range(1000, 8000);
                it.i_val = amp + $signed($urandom_range(0, 4000)) - 2000;
                it.q_val = $signed($urandom_range(0, 4000)) - 2000;
            end
        endcase
        return it;
    endfunction

    // input driver
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        int       gap_left;
        iq_item_t it;
        estimate_t res;
        if (!rst_n)
        begin
            in_chan.valid      <= 1'b0;
            in_chan.in_phase   <= '0;
            in_chan.quadrature <= '0;
            gap_left = 0;
        end
        else if (!in_chan.valid || in_chan.ready)
        begin
            if (in_chan.valid && in_chan.ready)
            begin
                it.i_val = in_chan.in_phase;
                it.q_val = in_chan.quadrature;
                res = cn0_predict(it);
                estimate_q.push_back(res);
            end
            if (gap_left > 0)
            begin
                in_chan.valid <= 1'b0;
                gap_left--;
            end
            else if (pending_items.size() > 0)
            begin
                it = pending_items.pop_front();
                in_chan.in_phase   <= it.i_val;
                in_chan.quadrature <= it.q_val;
                in_chan.valid      <= 1'b1;
                gap_left = pick_gap();
            end
            else
                in_chan.valid <= 1'b0;
        end
    end

    // output monitor
    always @(posedge clk or negedge rst_n)
    begin : check_estimates
        int        stall_left;
        estimate_t want;
        if (!rst_n)
        begin
            out_chan.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_chan.valid && out_chan.ready)
            begin
                if (estimate_q.size() == 0)
                    report("estimate with nothing expected");
                else
                begin
                    want = estimate_q.pop_front();
                    if (out_chan.cn0_estimate !== want.cn0)
                        report($sformatf("cn0_estimate %0d, expected %0d",
                                         out_chan.cn0_estimate, want.cn0));
                    if (out_chan.estimate_live !== want.live)
                        report($sformatf("estimate_live %0b, expected %0b",
                                         out_chan.estimate_live, want.live));
                end
            end
            if (stall_left > 0)
            begin
                out_chan.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_chan.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("snv_cn0_estimator_top test failed");
            $finish;
        end
    end

    task automatic reg_write(input snv_reg_t idx, input logic [15:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        reg_update(idx, data);
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !in_chan.valid && estimate_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic add_item(input int i_v, input int q_v, input int count);
        iq_item_t it;
        it.i_val = i_v;
        it.q_val = q_v;
        repeat (count) pending_items.push_back(it);
    endtask

    task automatic add_random(input int count);
        repeat (count) pending_items.push_back(random_item());
    endtask

    initial
    begin
        errors      = 0;
        idle_cycles = 0;
        gaps_on     = 1'b1;
        cfg_write   = 1'b0;
        cfg_index   = REG_IIR_COEF;
        cfg_data    = '0;
        warm_left   = WARMUP;
        amp_avg     = 0;
        pow_avg     = 0;
        alpha       = ALPHA_RST;
        bw_offset   = '0;
        last_est    = INIT_EST;
        rst_n       = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // warm-up with extreme samples, then saturation, no signal, nsr clamp
        reg_write(REG_INIT_EST, $urandom);
        reg_write(REG_IIR_COEF, 16'hffff);
        reg_write(REG_BW_OFFSET, 16'h7fff);
        reg_write(REG_UNUSED, $urandom);
        add_item(-32768, -32768, 2);
        add_item(32767, 32767, 2);
        add_item(32767, -32768, 2);
        add_item(-32768, 32767, 2);
        add_item(0, 0, 2);
        add_item(-1, 1, 2);
        add_item(1000, 0, 8);
        add_item(-1000, 0, 4);
        add_item(0, 32767, 3);
        drain();
        reg_write(REG_IIR_COEF, 16);
        reg_write(REG_BW_OFFSET, 16'h8000);
        reg_write(REG_INIT_EST, $urandom);
        add_item(1, 32767, 3);
        add_random(100);
        drain();

        gaps_on = 1'b0;
        reg_write(REG_IIR_COEF, 0);
        reg_write(REG_BW_OFFSET, 0);
        add_random(100);
        drain();

        gaps_on = 1'b1;
        repeat (4)
        begin
            reg_write(REG_IIR_COEF, $urandom);
            reg_write(REG_BW_OFFSET, $signed($urandom_range(0, 8000)) - 4000);
            reg_write(REG_UNUSED, $urandom);
            add_random(85);
            drain();
        end

        if (estimate_q.size() != 0)
            report("estimates never delivered");
        if (errors == 0)
            $display("snv_cn0_estimator_top test passed");
        else
            $display("snv_cn0_estimator_top test failed");
        $finish;
    end

endmodule

/* snv_cn0_estimator_top.f */
design/snv_pkg.sv
design/snv_in_if.sv
design/snv_out_if.sv
design/snv_datapath.sv
design/snv_controller.sv
design/snv_cn0_estimator_top.sv
sim/snv_cn0_estimator_top_tb.sv
